/* rtl/core/phpc_pkg.sv */
// Package for the PI heater power controller: field widths, register
// indexes, reset values and the structs shared by the top level and the
// per-tick datapath. No dependencies.
package phpc_pkg;

	// Field widths
	localparam int unsigned TempW   = 11;
	localparam int unsigned GainW   = 8;
	localparam int unsigned IntervW = 16;
	localparam int unsigned PowerW  = 14;
	localparam int unsigned SumW    = 16;
	localparam int unsigned IndexW  = 3;
	localparam int unsigned DataW   = 16;

	// Register indexes on the write port
	localparam logic [IndexW-1:0] RegPropGain  = 3'd0;
	localparam logic [IndexW-1:0] RegIntegGain = 3'd1;
	localparam logic [IndexW-1:0] RegInterval  = 3'd2;
	localparam logic [IndexW-1:0] RegMaxPower  = 3'd3;
	localparam logic [IndexW-1:0] RegMinPower  = 3'd4;
	localparam logic [IndexW-1:0] RegCutMargin = 3'd5;

	// Register reset values
	localparam logic [GainW-1:0]   PropGainRst  = 8'd50;
	localparam logic [GainW-1:0]   IntegGainRst = 8'd5;
	localparam logic [IntervW-1:0] IntervalRst  = 16'd20;
	localparam logic [PowerW-1:0]  MaxPowerRst  = 14'd7500;
	localparam logic [PowerW-1:0]  MinPowerRst  = 14'd500;
	localparam logic [TempW-1:0]   CutMarginRst = 11'd20;

	// Configuration registers as seen by the datapath
	typedef struct packed {
		logic [GainW-1:0]   prop_gain;
		logic [GainW-1:0]   integ_gain;
		logic [IntervW-1:0] integ_interval;
		logic [PowerW-1:0]  max_power;
		logic [PowerW-1:0]  min_power;
		logic [TempW-1:0]   cutoff_margin;
	} cfg_t;

	// Controller state carried from one tick to the next
	typedef struct packed {
		logic signed [SumW-1:0] error_sum;
		logic [IntervW-1:0]     tick_count;
		logic [PowerW-1:0]      last_power;
	} state_t;

endpackage

/* rtl/core/pi_heater_power_controller_unit.sv */
// PI heater power controller with conditional-integration anti-windup.
// Top level: request and result channels, configuration registers, state.
// Depends on phpc_pkg and phpc_step.
//
// Usage:
//   Each request (measured_temp, target_temp) is one control tick and gives
//   exactly one result (drive_power, integral_value, overtemp_cut).
//   A request is taken when req_valid is high and req_stall is low; a result
//   is taken when res_valid is high and res_stall is low.
//   A request lands in an input register; the tick is then computed, the
//   controller state updated and the result register loaded. One request
//   per cycle is sustained while the receiver does not stall; the PI state
//   (integral, tick counter, last power) is updated in the same cycle as
//   the result register loads, so consecutive ticks follow with no gap.
//   While the receiver stalls, the result register holds its value; the
//   input register fills once more and then req_stall rises until the
//   result is taken.
//   Reset (arst_n low) empties both registers, clears the integral and tick
//   counter, sets last power to 500 and loads the register defaults.
//   Configuration is written through wr_en/wr_index/wr_data with no wait;
//   an index beyond the register list is ignored.
module pi_heater_power_controller_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [phpc_pkg::TempW-1:0]          measured_temp,
	input  logic [phpc_pkg::TempW-1:0]          target_temp,
	output logic                                res_valid,
	input  logic                                res_stall,
	output logic [phpc_pkg::PowerW-1:0]         drive_power,
	output logic signed [phpc_pkg::SumW-1:0]    integral_value,
	output logic                                overtemp_cut,
	input  logic                                wr_en,
	input  logic [phpc_pkg::IndexW-1:0]         wr_index,
	input  logic [phpc_pkg::DataW-1:0]          wr_data
);

	phpc_pkg::cfg_t   cfg_q;
	phpc_pkg::state_t state_q;
	phpc_pkg::state_t state_nxt;

	logic                        valid_s1;
	logic [phpc_pkg::TempW-1:0]  meas_s1;
	logic [phpc_pkg::TempW-1:0]  targ_s1;
	logic                        valid_s2;
	logic [phpc_pkg::PowerW-1:0] power_s2;
	logic signed [phpc_pkg::SumW-1:0] sum_s2;
	logic                        cut_s2;
	logic                        cut_nxt;
	logic                        req_take;
	logic                        advance;

	// Handshake: the result register frees when empty or taken
	assign advance   = !valid_s2 || !res_stall;
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain      <= phpc_pkg::PropGainRst;
			cfg_q.integ_gain     <= phpc_pkg::IntegGainRst;
			cfg_q.integ_interval <= phpc_pkg::IntervalRst;
			cfg_q.max_power      <= phpc_pkg::MaxPowerRst;
			cfg_q.min_power      <= phpc_pkg::MinPowerRst;
			cfg_q.cutoff_margin  <= phpc_pkg::CutMarginRst;
		end else if (wr_en) begin
			case (wr_index)
				phpc_pkg::RegPropGain:  cfg_q.prop_gain <= wr_data[phpc_pkg::GainW-1:0];
				phpc_pkg::RegIntegGain: cfg_q.integ_gain <= wr_data[phpc_pkg::GainW-1:0];
				phpc_pkg::RegInterval:  cfg_q.integ_interval <= wr_data;
				phpc_pkg::RegMaxPower:  cfg_q.max_power <= wr_data[phpc_pkg::PowerW-1:0];
				phpc_pkg::RegMinPower:  cfg_q.min_power <= wr_data[phpc_pkg::PowerW-1:0];
				phpc_pkg::RegCutMargin: cfg_q.cutoff_margin <= wr_data[phpc_pkg::TempW-1:0];
				default: ;
			endcase
		end
	end

	// Input register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			meas_s1 <= measured_temp;
			targ_s1 <= target_temp;
		end
	end

	phpc_step u_step (
		.cfg           (cfg_q),
		.cur           (state_q),
		.measured_temp (meas_s1),
		.target_temp   (targ_s1),
		.nxt           (state_nxt),
		.overtemp_cut  (cut_nxt)
	);

	// Controller state: advance once per tick moved to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.error_sum  <= '0;
			state_q.tick_count <= '0;
			state_q.last_power <= phpc_pkg::MinPowerRst;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register: valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register: payload
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			power_s2 <= state_nxt.last_power;
			sum_s2   <= state_nxt.error_sum;
			cut_s2   <= cut_nxt;
		end
	end

	assign res_valid      = valid_s2;
	assign drive_power    = power_s2;
	assign integral_value = sum_s2;
	assign overtemp_cut   = cut_s2;

endmodule

/* rtl/core/phpc_step.sv */
// Combinational datapath for one control tick: error, interval counter,
// conditional integration with saturation, PI sum and power clamp.
// Depends on phpc_pkg.
module phpc_step (
	input  phpc_pkg::cfg_t                       cfg,
	input  phpc_pkg::state_t                     cur,
	input  logic [phpc_pkg::TempW-1:0]           measured_temp,
	input  logic [phpc_pkg::TempW-1:0]           target_temp,
	output phpc_pkg::state_t                     nxt,
	output logic                                 overtemp_cut
);

	logic signed [11:0] err;
	logic               tick_hit;
	logic               integ_en;
	logic signed [16:0] sum_wide;
	logic signed [15:0] sum_sat;
	logic signed [15:0] sum_new;
	logic signed [20:0] p_term;
	logic signed [24:0] i_term;
	logic signed [25:0] raw;
	logic signed [25:0] val;
	logic signed [12:0] neg_margin;
	logic signed [25:0] max_ext;
	logic signed [25:0] min_ext;
	logic [phpc_pkg::PowerW-1:0] power;

	// Error is setpoint minus measurement
	assign err = $signed({1'b0, target_temp}) - $signed({1'b0, measured_temp});

	// Interval counter: wrap to zero on a hit, otherwise advance
	assign tick_hit = (cur.tick_count == cfg.integ_interval);
	assign nxt.tick_count = tick_hit ? '0 : cur.tick_count + 16'd1;

	// Integrate only on an interval hit, and only when the previous power sat at neither limit
	assign integ_en = tick_hit && (cur.last_power != cfg.max_power)
		&& (cur.last_power != cfg.min_power);

	// Saturating 16-bit accumulate
	assign sum_wide = $signed({cur.error_sum[15], cur.error_sum})
		+ $signed({{5{err[11]}}, err});
	always_comb begin
		if (sum_wide[16] != sum_wide[15]) begin
			sum_sat = sum_wide[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			sum_sat = sum_wide[15:0];
		end
	end
	assign sum_new = integ_en ? sum_sat : cur.error_sum;
	assign nxt.error_sum = sum_new;

	// PI sum; both gains are unsigned
	assign p_term = $signed({1'b0, cfg.prop_gain}) * err;
	assign i_term = $signed({1'b0, cfg.integ_gain}) * sum_new;
	assign raw = $signed({{5{p_term[20]}}, p_term}) + $signed({i_term[24], i_term});

	// Overtemperature cutoff forces minimum power before the clamp
	assign neg_margin = 13'sd0 - $signed({2'b00, cfg.cutoff_margin});
	assign overtemp_cut = ($signed({err[11], err}) < neg_margin);

	assign max_ext = $signed({12'd0, cfg.max_power});
	assign min_ext = $signed({12'd0, cfg.min_power});
	assign val = overtemp_cut ? min_ext : raw;

	// Clamp: upper bound tested first
	always_comb begin
		if (val > max_ext) begin
			power = cfg.max_power;
		end else if (val < min_ext) begin
			power = cfg.min_power;
		end else begin
			power = val[phpc_pkg::PowerW-1:0];
		end
	end
	assign nxt.last_power = power;

endmodule

/* rtl/core/phpc_checker.sv */
// Port-level checker for the PI heater power controller, bound to the top
// level. Depends on phpc_pkg and pi_heater_power_controller_unit.
module phpc_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	input  logic                                req_stall,
	input  logic                                res_valid,
	input  logic                                res_stall,
	input  logic [phpc_pkg::PowerW-1:0]         drive_power,
	input  logic signed [phpc_pkg::SumW-1:0]    integral_value,
	input  logic                                overtemp_cut
);

	// Push back on requests only while a result is held by the receiver
	assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (res_valid && res_stall))
	else $error("request stalled without a held result");

	// A fresh result follows a request taken earlier through the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_valid && !req_stall, 2))
	else $error("result appeared without a matching request");

	// A stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(drive_power)
			&& $stable(integral_value) && $stable(overtemp_cut)))
	else $error("stalled result changed");

endmodule

bind pi_heater_power_controller_unit phpc_checker u_phpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.drive_power    (drive_power),
	.integral_value (integral_value),
	.overtemp_cut   (overtemp_cut)
);
